// ----- rtl/etpc_pkg.sv -----
// ----------------------------------------------------------------------------
// etpc_pkg
// Shared types, codes and the CRC-8 step for the telemetry poller.
// ----------------------------------------------------------------------------
package etpc_pkg;

    // Default sizing handed to the top level
    localparam int MAX_MOTORS_DEF = 8;
    localparam int AGE_LIMIT_DEF  = 255;

    // Frame layout: nine payload bytes and one CRC byte
    localparam int FRAME_BYTES = 10;
    localparam int FCNT_W      = 4;

    // CRC-8, polynomial x^8 + x^2 + x + 1, init zero
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Register reset values
    localparam logic [3:0]  MOTOR_COUNT_RST = 4'd4;
    localparam logic [15:0] BOOT_DELAY_RST  = 16'd5000;
    localparam logic [15:0] TIMEOUT_RST     = 16'd100;
    localparam logic [7:0]  AGE_RST         = 8'hFF;

    // Configuration register index
    typedef enum logic [1:0] {
        CFG_MOTOR_COUNT = 2'd0,
        CFG_BOOT_DELAY  = 2'd1,
        CFG_TIMEOUT     = 2'd2
    } cfg_idx_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_WAIT    = 3'd0,
        EV_REQ     = 3'd1,
        EV_OK      = 3'd2,
        EV_CRC     = 3'd3,
        EV_TIMEOUT = 3'd4
    } ev_t;

    // Input item: serial byte or millisecond tick
    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } item_t;

    // Result item
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  motor;
        logic [7:0]  temperature;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [15:0] consumption;
        logic [15:0] rpm;
        logic [7:0]  data_age;
    } result_t;

    // Fold one byte into the running CRC, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] acc;
        acc = crc ^ din;
        for (int b = 0; b < 8; b++) begin
            if ((acc & CRC_MSB) != 8'h00)
            begin
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/etpc_if.sv -----
// ----------------------------------------------------------------------------
// etpc interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel
interface etpc_item_if;
    logic                valid;
    logic                ready;
    etpc_pkg::item_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface etpc_result_if;
    logic                valid;
    logic                ready;
    etpc_pkg::result_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Register write channel
interface etpc_cfg_if;
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [15:0]         wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/esc_telemetry_poll_crc8_decoder.sv -----
// ----------------------------------------------------------------------------
// esc_telemetry_poll_crc8_decoder
// Round-robin telemetry poller with CRC-8 frame check and per-motor data age.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transfer
//  item    | in  | func, rx_byte, time_ms                   | valid && ready
//  result  | out | event_res, motor, decoded fields, age    | valid && ready
//  cfg     | in  | index, wdata (motor_count, boot, timeout)| valid && ready
//
//  One item per cycle unless refused. A tick is evaluated at its transfer
//  and registered into the finishing stage with its age memory read; the
//  result sits in the output register. Bytes give no result. The age memory
//  is read once per tick and written when a poll ends, with a bypass for a
//  write landing in the same cycle as the next read. Reset: startup phase,
//  all ages read as 255 through per-entry valid bits. A stalled result
//  holds the finishing stage; input is refused only while both are full.
// ----------------------------------------------------------------------------
module esc_telemetry_poll_crc8_decoder #(
    parameter int MAX_MOTORS = etpc_pkg::MAX_MOTORS_DEF,
    parameter int AGE_LIMIT  = etpc_pkg::AGE_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    etpc_item_if.sink           item,
    etpc_result_if.source       result,
    etpc_cfg_if.sink            cfg
);
    import etpc_pkg::*;

    localparam int MOTOR_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int MC_W    = 4;
    localparam int CMP_W   = (MOTOR_W + 1 > MC_W) ? MOTOR_W + 1 : MC_W;
    localparam int FIDX_W  = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {
        PH_STARTUP = 3'b001,
        PH_READY   = 3'b010,
        PH_PENDING = 3'b100
    } phase_t;

    // Finishing stage control
    typedef struct packed {
        ev_t                ev;
        logic [MOTOR_W-1:0] motor;
        logic               fwd_hit;
        logic [7:0]         fwd_age;
    } s2_t;

    // Registers
    logic [3:0]         motor_count_reg;
    logic [15:0]        boot_delay_reg;
    logic [15:0]        timeout_reg;
    phase_t             phase_reg, phase_next;
    logic [31:0]        req_time_reg, req_time_next;
    logic [MOTOR_W-1:0] cur_motor_reg, cur_motor_next;
    logic [FCNT_W-1:0]  rx_cnt_reg, rx_cnt_next;
    logic               frame_open_reg, frame_open_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         frame_reg [FRAME_BYTES];
    logic               s2_valid_reg;
    s2_t                s2_reg, s2_next;
    logic               out_valid_reg;
    result_t            out_reg, out_next;

    // Age memory and its valid bits
    logic [7:0]            age_mem [MAX_MOTORS];
    logic [MAX_MOTORS-1:0] age_vld_reg;
    logic [7:0]            age_rd_reg;
    logic                  age_rd_vld_reg;

    logic               item_xfer, tick_xfer, byte_xfer;
    logic               out_free, s2_move;
    logic               age_we;
    logic [7:0]         age_wdata, age_cur;
    logic [31:0]        deadline;
    logic [CMP_W-1:0]   motor_inc;
    logic               byte_store;

    // Handshake
    assign out_free   = !out_valid_reg || result.ready;
    assign s2_move    = s2_valid_reg && out_free;
    assign item.ready = !s2_valid_reg || out_free;
    assign cfg.ready  = 1'b1;
    assign item_xfer  = item.valid && item.ready;
    assign tick_xfer  = item_xfer && item.data.func;
    assign byte_xfer  = item_xfer && !item.data.func;
    assign byte_store = byte_xfer && frame_open_reg && (rx_cnt_reg < FCNT_W'(FRAME_BYTES));

    assign deadline  = req_time_reg + {16'h0000, timeout_reg};
    assign motor_inc = CMP_W'(cur_motor_reg) + CMP_W'(1);

    // Evaluate a tick against the poll state
    always_comb
    begin
        phase_next      = phase_reg;
        req_time_next   = req_time_reg;
        cur_motor_next  = cur_motor_reg;
        rx_cnt_next     = rx_cnt_reg;
        frame_open_next = frame_open_reg;
        crc_next        = crc_reg;
        s2_next.ev      = EV_WAIT;
        s2_next.motor   = cur_motor_reg;
        s2_next.fwd_hit = age_we && (s2_reg.motor == cur_motor_reg);
        s2_next.fwd_age = age_wdata;
        if (byte_store)
        begin
            rx_cnt_next = rx_cnt_reg + FCNT_W'(1);
            if (rx_cnt_reg < FCNT_W'(FRAME_BYTES - 1))
            begin
                crc_next = crc8_byte(crc_reg, item.data.rx_byte);
            end
        end
        if (tick_xfer)
        begin
            case (phase_reg)
                PH_READY:
                begin
                    req_time_next   = item.data.time_ms;
                    rx_cnt_next     = '0;
                    frame_open_next = 1'b1;
                    crc_next        = 8'h00;
                    phase_next      = PH_PENDING;
                    s2_next.ev      = EV_REQ;
                end
                PH_PENDING:
                begin
                    if (item.data.time_ms >= deadline)
                    begin
                        s2_next.ev = EV_TIMEOUT;
                    end
                    else if (rx_cnt_reg == FCNT_W'(FRAME_BYTES))
                    begin
                        s2_next.ev = (crc_reg == frame_reg[FRAME_BYTES-1]) ? EV_OK : EV_CRC;
                    end
                    if (s2_next.ev != EV_WAIT)
                    begin
                        phase_next = PH_READY;
                        if (motor_inc >= CMP_W'(motor_count_reg) ||
                            motor_inc >= CMP_W'(MAX_MOTORS))
                        begin
                            cur_motor_next = '0;
                        end
                        else
                        begin
                            cur_motor_next = motor_inc[MOTOR_W-1:0];
                        end
                    end
                end
                default:
                begin
                    if (item.data.time_ms >= {16'h0000, boot_delay_reg})
                    begin
                        phase_next = PH_READY;
                    end
                end
            endcase
        end
    end

    // Finish a tick: update the motor's age and build the result
    always_comb
    begin
        age_cur   = s2_reg.fwd_hit ? s2_reg.fwd_age : (age_rd_vld_reg ? age_rd_reg : AGE_RST);
        age_wdata = age_cur;
        case (s2_reg.ev)
            EV_OK:
            begin
                age_wdata = 8'h00;
            end
            EV_CRC, EV_TIMEOUT:
            begin
                if (age_cur < 8'(AGE_LIMIT))
                begin
                    age_wdata = age_cur + 8'd1;
                end
            end
            default:
            begin
                age_wdata = age_cur;
            end
        endcase
        age_we = s2_move && (s2_reg.ev == EV_OK || s2_reg.ev == EV_CRC ||
                             s2_reg.ev == EV_TIMEOUT);

        out_next             = '0;
        out_next.event_res   = s2_reg.ev;
        out_next.motor       = 3'(s2_reg.motor);
        out_next.data_age    = age_wdata;
        if (s2_reg.ev == EV_OK)
        begin
            out_next.temperature = frame_reg[0];
            out_next.voltage     = {frame_reg[1], frame_reg[2]};
            out_next.current     = {frame_reg[3], frame_reg[4]};
            out_next.consumption = {frame_reg[5], frame_reg[6]};
            out_next.rpm         = {frame_reg[7], frame_reg[8]};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_count_reg <= MOTOR_COUNT_RST;
            boot_delay_reg  <= BOOT_DELAY_RST;
            timeout_reg     <= TIMEOUT_RST;
            phase_reg       <= PH_STARTUP;
            req_time_reg    <= '0;
            cur_motor_reg   <= '0;
            rx_cnt_reg      <= '0;
            frame_open_reg  <= 1'b0;
            crc_reg         <= 8'h00;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            age_vld_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MOTOR_COUNT: motor_count_reg <= cfg.wdata[3:0];
                    CFG_BOOT_DELAY:  boot_delay_reg  <= cfg.wdata;
                    CFG_TIMEOUT:     timeout_reg     <= cfg.wdata;
                    default:         motor_count_reg <= motor_count_reg;
                endcase
            end
            phase_reg      <= phase_next;
            req_time_reg   <= req_time_next;
            cur_motor_reg  <= cur_motor_next;
            rx_cnt_reg     <= rx_cnt_next;
            frame_open_reg <= frame_open_next;
            crc_reg        <= crc_next;
            if (tick_xfer)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (age_we)
            begin
                age_vld_reg[s2_reg.motor] <= 1'b1;
            end
        end
    end

    // Payload registers: frame bytes, stage and output data
    always_ff @(posedge clk)
    begin
        if (byte_store)
        begin
            frame_reg[rx_cnt_reg[FIDX_W-1:0]] <= item.data.rx_byte;
        end
        if (tick_xfer)
        begin
            s2_reg <= s2_next;
        end
        if (s2_move)
        begin
            out_reg <= out_next;
        end
    end

    // Age memory: at most one write and one registered read per cycle, the read on a tick
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[s2_reg.motor] <= age_wdata;
        end
        if (tick_xfer)
        begin
            age_rd_reg     <= age_mem[cur_motor_reg];
            age_rd_vld_reg <= age_vld_reg[cur_motor_reg];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

`ifndef SYNTHESIS
    // A full finishing stage behind a stalled result blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("item accepted while finishing stage is blocked");

    // Byte count never passes the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= FCNT_W'(FRAME_BYTES))
        else $error("frame byte count overrun");

    // A decoded frame always reports a fresh age
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.event_res == EV_OK) |-> (result.data.data_age == 8'h00))
        else $error("decoded frame with nonzero age");

    // Waiting for a reply implies an open frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PENDING) |-> frame_open_reg)
        else $error("pending phase without open frame");
`endif

endmodule
